// ----- rtl/mft_pkg.sv -----
// Shared types and constants for the motor feedback multi-turn tracker.
// No dependencies.
package mft_pkg;

    localparam logic [10:0]        FIRST_ID_RESET = 11'd513;
    localparam logic signed [16:0] JUMP_LIMIT     = 17'sd4096;
    localparam int unsigned        TURN_SHIFT     = 13;   // 8192 counts per turn

    // Decoded feedback frame
    typedef struct packed {
        logic               bus;
        logic [2:0]         motor;
        logic [15:0]        angle;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         temp;
    } frame_t;

    // Per-slot tracking state, one RAM word
    typedef struct packed {
        logic [15:0] prev_angle;
        logic [15:0] offset;
        logic [31:0] revs;
        logic [5:0]  count;
    } slot_state_t;

    // Updated slot, ready for total-angle assembly
    typedef struct packed {
        frame_t      frame;
        logic [31:0] revs;
        logic [15:0] offset;
        logic        cal;
    } update_t;

endpackage

// ----- rtl/mft_if.sv -----
// Channel interfaces of the motor feedback multi-turn tracker:
// feedback frames in, results out, configuration writes. No dependencies.
interface mft_feedback_if;
    logic        valid;
    logic        ready;
    logic        bus_index;
    logic [10:0] frame_id;
    logic [7:0]  angle_high;
    logic [7:0]  angle_low;
    logic [7:0]  speed_high;
    logic [7:0]  speed_low;
    logic [7:0]  current_high;
    logic [7:0]  current_low;
    logic [7:0]  temperature_byte;

    modport source (output valid, bus_index, frame_id, angle_high, angle_low, speed_high,
                    speed_low, current_high, current_low, temperature_byte, input ready);
    modport sink   (input valid, bus_index, frame_id, angle_high, angle_low, speed_high,
                    speed_low, current_high, current_low, temperature_byte, output ready);
endinterface

interface mft_result_if;
    logic               valid;
    logic               ready;
    logic               out_bus;
    logic [2:0]         motor_index;
    logic [15:0]        raw_angle;
    logic signed [15:0] shaft_speed;
    logic signed [15:0] motor_current;
    logic [7:0]         temperature;
    logic signed [31:0] abs_position;
    logic               calibrating;

    modport source (output valid, out_bus, motor_index, raw_angle, shaft_speed, motor_current,
                    temperature, abs_position, calibrating, input ready);
    modport sink   (input valid, out_bus, motor_index, raw_angle, shaft_speed, motor_current,
                    temperature, abs_position, calibrating, output ready);
endinterface

interface mft_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/mft_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read data.
// Read of the address being written returns the old contents. No dependencies.
module mft_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mft_slot_update.sv -----
// Read-modify-write of per-slot tracking state: state RAM, valid bits,
// same-slot forwarding and unwrap logic. Depends on mft_pkg and mft_ram.
module mft_slot_update
    import mft_pkg::*;
#(
    parameter int unsigned SLOTS      = 14,
    parameter int unsigned CAL_FRAMES = 50,
    parameter int unsigned SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,      // accepted frame inside the motor window
    input  logic [SLOT_W-1:0] load_slot,
    input  frame_t            load_frame,
    output logic              load_ready,
    output logic              upd_valid,
    output update_t           upd_data,
    input  logic              upd_take
);

    logic              s1_valid_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    frame_t            s1_frame_reg;
    logic              fwd_hit_reg;
    slot_state_t       fwd_state_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic              s2_valid_reg;
    update_t           s2_data_reg;

    logic              s1_fire;
    logic              s2_free;
    logic [69:0]       ram_rdata;
    slot_state_t       state_cur;
    slot_state_t       state_new;
    logic              cal;
    logic signed [16:0] delta;

    assign s2_free    = !s2_valid_reg || upd_take;
    assign s1_fire    = s1_valid_reg && s2_free;
    assign load_ready = !s1_valid_reg || s1_fire;

    mft_ram #(
        .WIDTH  ($bits(slot_state_t)),
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_slot_reg),
        .wdata (state_new),
        .re    (load),
        .raddr (load_slot),
        .rdata (ram_rdata)
    );

    // Forwarded write wins; never-written slots read as zero.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            state_cur = fwd_state_reg;
        end
        else if (valid_reg[s1_slot_reg])
        begin
            state_cur = slot_state_t'(ram_rdata);
        end
        else
        begin
            state_cur = '0;
        end
    end

    always_comb
    begin
        cal       = (32'(state_cur.count) <= CAL_FRAMES);
        delta     = $signed({1'b0, s1_frame_reg.angle}) - $signed({1'b0, state_cur.prev_angle});
        state_new = state_cur;
        state_new.prev_angle = s1_frame_reg.angle;
        if (cal)
        begin
            state_new.count  = 6'(state_cur.count + 6'd1);
            state_new.offset = s1_frame_reg.angle;
        end
        else if (delta > JUMP_LIMIT)
        begin
            state_new.revs = state_cur.revs - 32'd1;
        end
        else if (delta < -JUMP_LIMIT)
        begin
            state_new.revs = state_cur.revs + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_fire && (s1_slot_reg == load_slot);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                s2_valid_reg           <= 1'b1;
                valid_reg[s1_slot_reg] <= 1'b1;
            end
            else if (upd_take)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_slot_reg   <= load_slot;
            s1_frame_reg  <= load_frame;
            fwd_state_reg <= state_new;
        end
        if (s1_fire)
        begin
            s2_data_reg.frame  <= s1_frame_reg;
            s2_data_reg.revs   <= state_new.revs;
            s2_data_reg.offset <= state_new.offset;
            s2_data_reg.cal    <= cal;
        end
    end

    assign upd_valid = s2_valid_reg;
    assign upd_data  = s2_data_reg;

endmodule

// ----- rtl/mft_result_stage.sv -----
// Output register: assembles the wrapped total angle and holds the result
// transaction. Depends on mft_pkg and mft_if.
module mft_result_stage
    import mft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         upd_valid,
    input  update_t      upd_data,
    output logic         upd_take,
    mft_result_if.source result
);

    logic        out_valid_reg;
    update_t     out_data_reg;
    logic [31:0] total_reg;
    logic [31:0] total_next;

    assign upd_take = upd_valid && (!out_valid_reg || result.ready);

    // revs * 8192 + angle - offset, modulo 2^32
    assign total_next = (upd_data.revs << TURN_SHIFT) + {16'd0, upd_data.frame.angle}
                        - {16'd0, upd_data.offset};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (upd_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_take)
        begin
            out_data_reg <= upd_data;
            total_reg    <= total_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_bus       = out_data_reg.frame.bus;
    assign result.motor_index   = out_data_reg.frame.motor;
    assign result.raw_angle     = out_data_reg.frame.angle;
    assign result.shaft_speed   = out_data_reg.frame.speed;
    assign result.motor_current = out_data_reg.frame.current;
    assign result.temperature   = out_data_reg.frame.temp;
    assign result.abs_position  = $signed(total_reg);
    assign result.calibrating   = out_data_reg.cal;

endmodule

// ----- rtl/motor_feedback_multiturn_tracker.sv -----
// Top level of the motor feedback multi-turn tracker.
// Depends on mft_pkg, mft_if, mft_ram, mft_slot_update, mft_result_stage.
//
// Tracks the absolute position of up to MOTORS_PER_BUS motors on each of BUS_COUNT
// buses from their feedback frames. A frame whose identifier lies in the window
// first_motor_id .. first_motor_id+MOTORS_PER_BUS-1 (no wrap past 2047) on a present
// bus updates that motor's slot and yields one result transaction; any other frame
// is taken and dropped. For the first CAL_FRAMES+1 frames of a slot the offset tracks
// the raw angle and the result is flagged calibrating; afterwards an angle step above
// +4096 counts one turn down and a step below -4096 one turn up. abs_position is
// turns*8192 + angle - offset, wrapping at 32 bits. Throughput is one frame per clock
// sustained while the output is not stalled: slot state lives in one synchronous RAM
// read when a frame is taken and written back from the update stage, with a
// forwarding register covering back-to-back frames for the same motor. A taken frame
// passes the RAM read, the update/write-back and the total-angle add into the output
// register. Up to three frames can be in flight, so the input takes frames while a
// result waits, until the stages fill. Slot state reads as zero after reset through
// per-slot valid bits; there is no clearing pass. first_motor_id resets to 513 and
// may be rewritten only while the block is idle; cfg.ready is always high.
module motor_feedback_multiturn_tracker
    import mft_pkg::*;
#(
    parameter int unsigned MOTORS_PER_BUS = 7,
    parameter int unsigned BUS_COUNT      = 2,
    parameter int unsigned CAL_FRAMES     = 50
) (
    input  logic           clk,
    input  logic           rst_n,
    mft_feedback_if.sink   feedback,
    mft_result_if.source   result,
    mft_cfg_if.sink        cfg
);

    localparam int unsigned SLOTS  = MOTORS_PER_BUS * BUS_COUNT;
    localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [10:0]       first_id_reg;

    logic [10:0]       id_diff;
    logic              bus_ok;
    logic              in_window;
    logic              accept;
    logic              load;
    logic [SLOT_W-1:0] slot;
    frame_t            frame;

    logic              upd_ready;
    logic              upd_valid;
    update_t           upd_data;
    logic              upd_take;

    // Configuration: single register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_id_reg <= FIRST_ID_RESET;
        end
        else if (cfg.valid)
        begin
            first_id_reg <= cfg.data;
        end
    end

    // Frame decode: window check and slot number
    assign id_diff   = feedback.frame_id - first_id_reg;
    assign bus_ok    = (BUS_COUNT > 1) || (feedback.bus_index == 1'b0);
    assign in_window = bus_ok && (feedback.frame_id >= first_id_reg)
                       && (32'(id_diff) < MOTORS_PER_BUS);
    assign slot      = SLOT_W'(32'(feedback.bus_index) * MOTORS_PER_BUS + 32'(id_diff[2:0]));

    assign frame.bus     = feedback.bus_index;
    assign frame.motor   = id_diff[2:0];
    assign frame.angle   = {feedback.angle_high, feedback.angle_low};
    assign frame.speed   = $signed({feedback.speed_high, feedback.speed_low});
    assign frame.current = $signed({feedback.current_high, feedback.current_low});
    assign frame.temp    = feedback.temperature_byte;

    // Out-of-window frames are taken and dropped here.
    assign feedback.ready = upd_ready;
    assign accept         = feedback.valid && upd_ready;
    assign load           = accept && in_window;

    mft_slot_update #(
        .SLOTS      (SLOTS),
        .CAL_FRAMES (CAL_FRAMES),
        .SLOT_W     (SLOT_W)
    ) u_slot_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_slot  (slot),
        .load_frame (frame),
        .load_ready (upd_ready),
        .upd_valid  (upd_valid),
        .upd_data   (upd_data),
        .upd_take   (upd_take)
    );

    mft_result_stage u_result_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_valid (upd_valid),
        .upd_data  (upd_data),
        .upd_take  (upd_take),
        .result    (result)
    );

endmodule

// ----- rtl/mft_checker.sv -----
// Port-level checks of the motor feedback multi-turn tracker and the bind
// that attaches them. Depends on motor_feedback_multiturn_tracker and mft_if.
module mft_checker #(
    parameter int unsigned MOTORS_PER_BUS = 7,
    parameter int unsigned BUS_COUNT      = 2
) (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_bus,
    input logic [2:0]  res_motor,
    input logic [31:0] res_total,
    input logic        res_cal
);

    // Stalled result stays up with its total unchanged
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_total))
        else $error("result dropped or changed while stalled");

    // Calibration frames have offset == angle, so total is whole turns
    a_cal_total: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_cal |-> res_total[12:0] == 13'd0)
        else $error("calibrating result with fractional turn");

    a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> 32'(res_motor) < MOTORS_PER_BUS)
        else $error("motor index outside window");

    a_bus_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> 32'(res_bus) < BUS_COUNT)
        else $error("result for absent bus");

endmodule

bind motor_feedback_multiturn_tracker mft_checker #(
    .MOTORS_PER_BUS (MOTORS_PER_BUS),
    .BUS_COUNT      (BUS_COUNT)
) u_mft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_bus   (result.out_bus),
    .res_motor (result.motor_index),
    .res_total (result.abs_position),
    .res_cal   (result.calibrating)
);
